/* hw/rtl/sine_burst_generator_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the sine burst generator checker
// ---------------------------------------------------------------------------
`ifndef SINE_BURST_GENERATOR_ASSERT_SVH
`define SINE_BURST_GENERATOR_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define SBG_ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the trigger
`define SBG_ASSERT_NEXT(name, clk, rst_n, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sbg_pkg.sv */
// ---------------------------------------------------------------------------
// sbg_pkg
// Shared widths, register codes, reset values and sine table builder for
// the sine burst generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbg_pkg;

    localparam int SBG_TABLE_BITS = 10;

    localparam int CHANNEL_W   = 3;
    localparam int SAMPLE_W    = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CYCLE_W     = 16;
    localparam int PERIOD_W    = 32;
    localparam int PHASE_W     = 32;
    localparam int AMP_W       = 31;
    localparam int MAG_W       = 31;
    localparam int PROD_W      = AMP_W + MAG_W;
    localparam int FRAC_BITS   = 30;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CYCLE_LENGTH  = 3'd0,
        REG_NUM_CYCLES    = 3'd1,
        REG_PERIOD_LENGTH = 3'd2,
        REG_PHASE_STEP    = 3'd3,
        REG_AMPLITUDE     = 3'd4
    } cfg_reg_t;

    localparam logic [CYCLE_W-1:0]  RST_CYCLE_LENGTH  = 16'd48;
    localparam logic [CYCLE_W-1:0]  RST_NUM_CYCLES    = 16'd1;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_LENGTH = 32'd48000;
    localparam logic [PHASE_W-1:0]  RST_PHASE_STEP    = 32'd89478485;
    localparam logic [AMP_W-1:0]    RST_AMPLITUDE     = 31'h7FFF_FFFF;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << FRAC_BITS;

    // Magnitude and sign of one table entry
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sbg_lookup_t;

    // Sine of m/quarter * pi/2 in unsigned Q30, truncated Taylor series
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned m,
                                                     input int unsigned table_bits);
        longint unsigned half_q;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        half_q = (64'd1 << (table_bits - 2)) >> 1;
        x      = (HALF_PI_Q30 * 64'(m) + half_q) >> (table_bits - 2);
        x2     = (x * x) >> FRAC_BITS;
        term   = x;
        pos    = x;
        neg    = 64'd0;
        term = ((term * x2) >> FRAC_BITS) / 6;   neg = neg + term;
        term = ((term * x2) >> FRAC_BITS) / 20;  pos = pos + term;
        term = ((term * x2) >> FRAC_BITS) / 42;  neg = neg + term;
        term = ((term * x2) >> FRAC_BITS) / 72;  pos = pos + term;
        term = ((term * x2) >> FRAC_BITS) / 110; neg = neg + term;
        term = ((term * x2) >> FRAC_BITS) / 156; pos = pos + term;
        term = ((term * x2) >> FRAC_BITS) / 210; neg = neg + term;
        if (neg >= pos)
        begin
            return '0;
        end
        pos = pos - neg;
        if (pos > ONE_Q30)
        begin
            pos = ONE_Q30;
        end
        return pos[MAG_W-1:0];
    endfunction

endpackage

/* hw/rtl/sbg_if.sv */
// ---------------------------------------------------------------------------
// Sine burst generator channels
// Valid/ready channels for sample slots, output samples and register writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sbg_slot_if;
    import sbg_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] channel;
    modport source (output valid, output channel, input ready);
    modport sink   (input valid, input channel, output ready);
endinterface

interface sbg_sample_if;
    import sbg_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface sbg_cfg_if;
    import sbg_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/sine_burst_generator.sv */
// ---------------------------------------------------------------------------
// sine_burst_generator
// Periodic tone burst: one signed 32-bit sample for every channel slot.
// ---------------------------------------------------------------------------
// Usage:
//   slot   : one transfer per channel slot; channel 0 opens a frame and
//            produces a fresh sample, other channels repeat the last one.
//   result : one sample transfer for every slot transfer, in slot order.
//   cfg    : register writes, always ready; write only while the block holds
//            no slot whose sample is still undelivered.
// Throughput: one slot per cycle while result.ready stays high.
// Pipeline: a slot passes through four registered stages before its
//   sample can be transferred out: counter and phase update, quarter-wave
//   table read, 31 by 31 amplitude multiply, rounding and sign.
// Reset: registers return to their defaults, the period position, burst
//   count, phase and held sample clear, and the pipe empties.
// Stall: while result.ready is low the output holds; back-pressure moves up
//   the pipe and slot.ready drops only once all four stages are occupied.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_burst_generator #(
    parameter int TABLE_BITS = sbg_pkg::SBG_TABLE_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    sbg_cfg_if.sink        cfg,
    sbg_slot_if.sink       slot,
    sbg_sample_if.source   result
);
    import sbg_pkg::*;

    // Configuration registers
    logic [CYCLE_W-1:0]  cycle_length_reg;
    logic [CYCLE_W-1:0]  num_cycles_reg;
    logic [PERIOD_W-1:0] period_length_reg;
    logic [PHASE_W-1:0]  phase_step_reg;
    logic [AMP_W-1:0]    amplitude_reg;

    // Burst state
    logic [PERIOD_W-1:0] position_reg, position_next;
    logic [31:0]         count_reg, count_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [SAMPLE_W-1:0] held_reg, held_next;

    // Pipe
    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic                  ch0_1_reg, ch0_2_reg, ch0_3_reg;
    logic                  burst_1_reg;
    logic [TABLE_BITS-1:0] idx_1_reg;
    logic                  neg_2_reg, neg_3_reg;
    logic [MAG_W-1:0]      mag_2_reg;
    logic [PROD_W-1:0]     prod_3_reg;
    logic [SAMPLE_W-1:0]   sample_reg, sample_next;

    logic                  adv1, adv2, adv3, adv4;
    logic                  slot_xfer, frame_start;
    logic                  period_start, in_burst;
    logic [31:0]           cur_count, limit;
    logic [PHASE_W-1:0]    cur_phase;
    logic [PERIOD_W:0]     position_inc;
    sbg_lookup_t           entry;
    logic [PROD_W-1:0]     rounded;
    logic [SAMPLE_W-1:0]   level;

    // Handshakes: each stage fills when empty or when it moves on
    assign adv4      = !v4_reg || result.ready;
    assign adv3      = !v3_reg || adv4;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign slot.ready = adv1;
    assign slot_xfer  = slot.valid && adv1;
    assign frame_start = slot_xfer && (slot.channel == '0);

    assign cfg.ready     = 1'b1;
    assign result.valid  = v4_reg;
    assign result.sample = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_length_reg  <= RST_CYCLE_LENGTH;
            num_cycles_reg    <= RST_NUM_CYCLES;
            period_length_reg <= RST_PERIOD_LENGTH;
            phase_step_reg    <= RST_PHASE_STEP;
            amplitude_reg     <= RST_AMPLITUDE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CYCLE_LENGTH:  cycle_length_reg  <= cfg.data[CYCLE_W-1:0];
                REG_NUM_CYCLES:    num_cycles_reg    <= cfg.data[CYCLE_W-1:0];
                REG_PERIOD_LENGTH: period_length_reg <= cfg.data[PERIOD_W-1:0];
                REG_PHASE_STEP:    phase_step_reg    <= cfg.data[PHASE_W-1:0];
                REG_AMPLITUDE:     amplitude_reg     <= cfg.data[AMP_W-1:0];
                default:           ;
            endcase
        end
    end

    // Frame: count and phase clear at period start, step only in burst
    always_comb
    begin
        period_start = (position_reg == '0);
        cur_count    = period_start ? '0 : count_reg;
        cur_phase    = period_start ? '0 : phase_reg;
        limit        = {16'b0, cycle_length_reg} * {16'b0, num_cycles_reg};
        in_burst     = cur_count < limit;
        position_inc = {1'b0, position_reg} + 33'd1;

        position_next = position_reg;
        count_next    = count_reg;
        phase_next    = phase_reg;
        if (frame_start)
        begin
            if (position_inc >= {1'b0, period_length_reg})
            begin
                position_next = '0;
            end
            else
            begin
                position_next = position_inc[PERIOD_W-1:0];
            end
            count_next = in_burst ? cur_count + 32'd1 : cur_count;
            phase_next = in_burst ? cur_phase + phase_step_reg : cur_phase;
        end
    end

    sbg_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .idx   (idx_1_reg),
        .entry (entry)
    );

    // Round half away from zero on the magnitude, then apply the sign
    always_comb
    begin
        rounded = prod_3_reg + (PROD_W'(1) << (FRAC_BITS - 1));
        level   = rounded[FRAC_BITS +: SAMPLE_W];
        if (neg_3_reg)
        begin
            level = '0 - level;
        end
        held_next   = held_reg;
        sample_next = held_reg;
        if (ch0_3_reg)
        begin
            sample_next = level;
            if (adv4 && v3_reg)
            begin
                held_next = level;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            count_reg    <= '0;
            phase_reg    <= '0;
            held_reg     <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
        end
        else
        begin
            position_reg <= position_next;
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            if (adv1)
            begin
                v1_reg <= slot.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (slot_xfer)
        begin
            ch0_1_reg   <= (slot.channel == '0);
            burst_1_reg <= in_burst;
            idx_1_reg   <= cur_phase[PHASE_W-1 -: TABLE_BITS];
        end
        if (adv2 && v1_reg)
        begin
            ch0_2_reg <= ch0_1_reg;
            neg_2_reg <= entry.neg;
            mag_2_reg <= burst_1_reg ? entry.mag : '0;
        end
        if (adv3 && v2_reg)
        begin
            ch0_3_reg  <= ch0_2_reg;
            neg_3_reg  <= neg_2_reg;
            prod_3_reg <= {{MAG_W{1'b0}}, amplitude_reg} * {{AMP_W{1'b0}}, mag_2_reg};
        end
        if (adv4 && v3_reg)
        begin
            sample_reg <= sample_next;
        end
    end

endmodule

/* hw/rtl/sbg_sine_rom.sv */
// ---------------------------------------------------------------------------
// sbg_sine_rom
// Full-wave sine lookup in Q30 from a quarter-wave constant table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbg_sine_rom #(
    parameter int TABLE_BITS = sbg_pkg::SBG_TABLE_BITS
) (
    input  logic [TABLE_BITS-1:0] idx,
    output sbg_pkg::sbg_lookup_t  entry
);
    import sbg_pkg::*;

    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam int M_W     = TABLE_BITS - 1;

    logic [MAG_W-1:0]    qtab [QUARTER+1];
    logic [1:0]          quadrant;
    logic [M_W-2:0]      offset;
    logic [M_W-1:0]      m;

    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_qtab
        localparam logic [MAG_W-1:0] QV = quarter_sine(g, TABLE_BITS);
        assign qtab[g] = QV;
    end

    assign quadrant = idx[TABLE_BITS-1 -: 2];
    assign offset   = idx[TABLE_BITS-3:0];

    // Mirror the odd quadrants, negate the lower half-wave
    always_comb
    begin
        if (quadrant[0])
        begin
            m = M_W'(QUARTER) - {1'b0, offset};
        end
        else
        begin
            m = {1'b0, offset};
        end
        entry.mag = qtab[m];
        entry.neg = quadrant[1];
    end

endmodule

/* hw/rtl/sbg_checker.sv */
// ---------------------------------------------------------------------------
// sbg_checker
// Port-level checks on the sine burst generator: occupancy and output hold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sine_burst_generator_assert.svh"

module sbg_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                slot_valid,
    input logic                                slot_ready,
    input logic                                result_valid,
    input logic                                result_ready,
    input logic signed [sbg_pkg::SAMPLE_W-1:0] result_sample
);
    import sbg_pkg::*;

    localparam logic [2:0] PIPE_DEPTH = 3'd4;

    logic [2:0] inflight_reg, inflight_next;
    logic       slot_xfer, result_xfer;

    assign slot_xfer   = slot_valid && slot_ready;
    assign result_xfer = result_valid && result_ready;
    assign inflight_next = inflight_reg + 3'(slot_xfer) - 3'(result_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `SBG_ASSERT_ALWAYS(a_inflight_max, clk, rst_n, inflight_reg <= PIPE_DEPTH, "slots in flight exceed pipe depth")
    `SBG_ASSERT_ALWAYS(a_ready_free, clk, rst_n, (inflight_reg < PIPE_DEPTH) |-> slot_ready, "slot refused while pipe has room")
    `SBG_ASSERT_ALWAYS(a_no_spurious, clk, rst_n, result_valid |-> (inflight_reg != 3'd0), "sample offered with no slot in flight")
    `SBG_ASSERT_NEXT(a_stall_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_sample), "stalled sample changed")

endmodule

bind sine_burst_generator sbg_checker u_sbg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .slot_valid    (slot.valid),
    .slot_ready    (slot.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_sample (result.sample)
);
